[rtl/partial_stack_mute_window_macros.svh]
// Assertion helpers shared by the checker of the mute window stacker.
`ifndef PARTIAL_STACK_MUTE_WINDOW_MACROS_SVH
`define PARTIAL_STACK_MUTE_WINDOW_MACROS_SVH

// Plain property sampled on the rising clock, muted while reset is low.
`define PSMW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Trigger in one cycle, consequence in the next.
`define PSMW_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[rtl/psmw_pkg.sv]
package psmw_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 56;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned PCT_MAX     = 100;
  localparam int unsigned ROUND_UP    = 99;
  localparam int unsigned RECIP_MUL   = 83887;  // ceil(2^23 / 100)
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned INTERVAL_W  = 16;
  localparam int unsigned SI_W        = 10;
  localparam int unsigned TI_W        = 6;
  localparam int unsigned TC_W        = 7;
  localparam int unsigned SC_W        = 4;
  localparam int unsigned SIDX_W      = 3;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned MUTE_W      = 16;
  localparam int unsigned TIME_W      = SI_W + INTERVAL_W;
  localparam int unsigned TIME_SW     = TIME_W + 1;
  localparam int unsigned US_PER_MS   = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IGNORE_MUTES = 3'd0,
    CFG_USE_TOP      = 3'd1,
    CFG_USE_BOTTOM   = 3'd2,
    CFG_STACK_COUNT  = 3'd3,
    CFG_START_TABLE  = 3'd4,
    CFG_END_TABLE    = 3'd5,
    CFG_INTERVAL     = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_STACK = 1'b1
  } req_e;

  typedef struct packed {
    logic                  ignore_mutes;
    logic                  use_top;
    logic                  use_bottom;
    logic [SC_W-1:0]       stack_count;
    logic [CFG_DATA_W-1:0] start_tbl;
    logic [CFG_DATA_W-1:0] end_tbl;
    logic [INTERVAL_W-1:0] interval;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ignore_mutes: 1'b0,
    use_top:      1'b1,
    use_bottom:   1'b0,
    stack_count:  4'd3,
    start_tbl:    56'd1101952,
    end_tbl:      56'd1647009,
    interval:     16'd4000
  };

  typedef struct packed {
    logic load_wr;
    logic req_latch;
    logic scan_step;
    logic win_calc;
    logic coef_mul;
    logic coef_div;
    logic k_clr;
    logic k_inc;
    logic acc_init;
    logic acc_step;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic cnt_zero;
    logic last_k;
    logic acc_end;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [PCT_W-1:0] pct_sat(input logic [CFG_DATA_W-1:0] tbl,
                                                input logic [SIDX_W-1:0] k);
    logic [PCT_W-1:0] p;
    p = tbl[PCT_W*k +: PCT_W];
    return (p > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : p;
  endfunction

endpackage

[rtl/partial_stack_mute_window.sv]
// Partial stack over a mute-bounded trace window. Load requests write one
// sample of one trace plus that trace's top and bottom mute times. The
// shared restoring divider is DW = 33+clog2(MAX_TRACES+1) bits wide (40 at
// the default size). The mute scan and the prefix-sum walk each take a read
// state and a compare or add state per trace for the registered memory
// read; the divider yields one quotient bit per cycle and dominates the run
// time of a stack request. Results leave through a single output register,
// so the block keeps computing the next stack while a result waits. Stores
// are not cleared at reset; read only what has been loaded.
module partial_stack_mute_window #(
  parameter int unsigned MAX_TRACES      = 64,
  parameter int unsigned MAX_SAMPLES     = 1024,
  parameter int unsigned MAX_STACK_COUNT = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [psmw_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [psmw_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // request channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  req_type_i,
  input  logic [psmw_pkg::TI_W-1:0]             trace_index_i,
  input  logic [psmw_pkg::SI_W-1:0]             sample_index_i,
  input  logic signed [psmw_pkg::VAL_W-1:0]     sample_value_i,
  input  logic signed [psmw_pkg::MUTE_W-1:0]    top_mute_ms_i,
  input  logic signed [psmw_pkg::MUTE_W-1:0]    bottom_mute_ms_i,
  input  logic [psmw_pkg::TC_W-1:0]             trace_count_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [psmw_pkg::SIDX_W-1:0]           stack_index_o,
  output logic [psmw_pkg::SI_W-1:0]             out_sample_index_o,
  output logic signed [psmw_pkg::VAL_W-1:0]     stack_value_o,
  output logic                                  last_o
);

  psmw_pkg::cfg_t cfg_q, cfg_d;
  psmw_pkg::cmd_t cmd;
  psmw_pkg::sts_t sts;

  // Register writes are masked to each field's width; unknown indexes drop.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (psmw_pkg::cfg_idx_e'(cfg_idx_i))
        psmw_pkg::CFG_IGNORE_MUTES: cfg_d.ignore_mutes = cfg_data_i[0];
        psmw_pkg::CFG_USE_TOP:      cfg_d.use_top      = cfg_data_i[0];
        psmw_pkg::CFG_USE_BOTTOM:   cfg_d.use_bottom   = cfg_data_i[0];
        psmw_pkg::CFG_STACK_COUNT:  cfg_d.stack_count  = cfg_data_i[psmw_pkg::SC_W-1:0];
        psmw_pkg::CFG_START_TABLE:  cfg_d.start_tbl    = cfg_data_i;
        psmw_pkg::CFG_END_TABLE:    cfg_d.end_tbl      = cfg_data_i;
        psmw_pkg::CFG_INTERVAL:     cfg_d.interval     = cfg_data_i[psmw_pkg::INTERVAL_W-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= psmw_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sequencer: scan, window, coefficients, prefix walk, divide and emit.
  psmw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Stores, counters, lanes, divider and the output register.
  psmw_dp #(
    .MAX_TRACES      (MAX_TRACES),
    .MAX_SAMPLES     (MAX_SAMPLES),
    .MAX_STACK_COUNT (MAX_STACK_COUNT)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .trace_index_i      (trace_index_i),
    .sample_index_i     (sample_index_i),
    .sample_value_i     (sample_value_i),
    .top_mute_ms_i      (top_mute_ms_i),
    .bottom_mute_ms_i   (bottom_mute_ms_i),
    .trace_count_i      (trace_count_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .stack_index_o      (stack_index_o),
    .out_sample_index_o (out_sample_index_o),
    .stack_value_o      (stack_value_o),
    .last_o             (last_o)
  );

endmodule

[rtl/psmw_div.sv]
module psmw_div #(
  parameter int unsigned DIV_W = 40,
  parameter int unsigned GAP_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIV_W-1:0] dividend_i,
  input  logic signed [GAP_W-1:0] divisor_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [DIV_W-1:0] dnd_q;
  logic [GAP_W-1:0] rem_q, dvs_q;
  logic             neg_q, zero_q;

  logic [GAP_W:0]   shifted;
  logic             fits;
  logic [DIV_W-1:0] max_pos, max_neg;

  assign shifted = {rem_q, dnd_q[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign max_pos = DIV_W'(33'h0_7FFF_FFFF);
  assign max_neg = DIV_W'(33'h0_8000_0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(DIV_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle on magnitudes.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dnd_q  <= dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
      dvs_q  <= divisor_i[GAP_W-1] ? GAP_W'(-divisor_i) : GAP_W'(divisor_i);
      neg_q  <= dividend_i[DIV_W-1] ^ divisor_i[GAP_W-1];
      zero_q <= (divisor_i == '0);
      rem_q  <= '0;
    end else if (run_q) begin
      rem_q <= fits ? GAP_W'(shifted - {1'b0, dvs_q}) : shifted[GAP_W-1:0];
      dnd_q <= {dnd_q[DIV_W-2:0], fits};
    end
  end

  always_comb begin
    if (zero_q) begin
      quo_o = '0;
    end else if (neg_q) begin
      quo_o = (dnd_q > max_neg) ? 32'sh8000_0000 : 32'(-dnd_q);
    end else begin
      quo_o = (dnd_q > max_pos) ? 32'sh7FFF_FFFF : 32'(dnd_q);
    end
  end

  assign done_o = done_q;

endmodule

[rtl/psmw_dp.sv]
module psmw_dp #(
  parameter int unsigned MAX_TRACES      = 64,
  parameter int unsigned MAX_SAMPLES     = 1024,
  parameter int unsigned MAX_STACK_COUNT = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  psmw_pkg::cfg_t                        cfg_i,
  input  psmw_pkg::cmd_t                        cmd_i,
  output psmw_pkg::sts_t                        sts_o,
  input  logic [psmw_pkg::TI_W-1:0]             trace_index_i,
  input  logic [psmw_pkg::SI_W-1:0]             sample_index_i,
  input  logic signed [psmw_pkg::VAL_W-1:0]     sample_value_i,
  input  logic signed [psmw_pkg::MUTE_W-1:0]    top_mute_ms_i,
  input  logic signed [psmw_pkg::MUTE_W-1:0]    bottom_mute_ms_i,
  input  logic [psmw_pkg::TC_W-1:0]             trace_count_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [psmw_pkg::SIDX_W-1:0]           stack_index_o,
  output logic [psmw_pkg::SI_W-1:0]             out_sample_index_o,
  output logic signed [psmw_pkg::VAL_W-1:0]     stack_value_o,
  output logic                                  last_o
);

  localparam int unsigned TW     = (MAX_TRACES > 1) ? $clog2(MAX_TRACES) : 1;
  localparam int unsigned LEN_W  = $clog2(MAX_TRACES + 1);
  localparam int unsigned DEPTH  = MAX_TRACES * MAX_SAMPLES;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SCW    = $clog2(MAX_STACK_COUNT + 1);
  localparam int unsigned KW     = (MAX_STACK_COUNT > 1) ? $clog2(MAX_STACK_COUNT) : 1;
  localparam int unsigned ACC_W  = psmw_pkg::VAL_W + LEN_W;
  localparam int unsigned DIV_W  = ACC_W + 1;
  localparam int unsigned GAP_W  = LEN_W + 1;
  localparam int unsigned X_W    = LEN_W + psmw_pkg::PCT_W;
  localparam int unsigned PROD_W = X_W + psmw_pkg::RECIP_W;

  // Storage
  logic signed [psmw_pkg::VAL_W-1:0]  smp_mem [DEPTH];
  logic signed [psmw_pkg::MUTE_W-1:0] top_mem [MAX_TRACES];
  logic signed [psmw_pkg::MUTE_W-1:0] bot_mem [MAX_TRACES];

  logic signed [psmw_pkg::VAL_W-1:0]  smp_rd_q;
  logic signed [psmw_pkg::MUTE_W-1:0] top_rd_q, bot_rd_q;

  // Request context
  logic [psmw_pkg::SI_W-1:0]   si_q;
  logic [LEN_W-1:0]            w_q;
  logic [psmw_pkg::TIME_W-1:0] t_q;
  logic                        in_range_q;
  logic [SCW-1:0]              cnt_q;

  // Scan and window
  logic [LEN_W-1:0] j_q, u_q, v_q, lo_q, len_q;
  logic             u_run_q, v_run_q;

  // Stack lanes
  logic [KW-1:0]             k_q;
  logic [X_W-1:0]            xm_q, xn_q;
  logic [LEN_W-1:0]          m_q  [MAX_STACK_COUNT];
  logic [LEN_W-1:0]          n_q  [MAX_STACK_COUNT];
  logic signed [ACC_W-1:0]   sm_q [MAX_STACK_COUNT];
  logic signed [ACC_W-1:0]   sn_q [MAX_STACK_COUNT];

  // Accumulation
  logic [LEN_W-1:0]        p_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [AW-1:0]           addr_q;

  logic                               out_valid_q;
  logic [psmw_pkg::SIDX_W-1:0]        out_k_q;
  logic [psmw_pkg::SI_W-1:0]          out_si_q;
  logic signed [psmw_pkg::VAL_W-1:0]  out_val_q;
  logic                               out_last_q;

  logic                                wr_ok;
  logic [AW-1:0]                       wr_addr;
  logic [TW-1:0]                       wr_tr;
  logic [LEN_W-1:0]                    w_sat;
  logic [SCW-1:0]                      cnt_sat;
  logic signed [psmw_pkg::TIME_SW-1:0] t_s, top_us, bot_us;
  logic                                mute_rd_en, smp_rd_en;
  logic [psmw_pkg::PCT_W-1:0]          ps, pe;
  logic [PROD_W-1:0]                   m_prod, n_prod;
  logic signed [DIV_W-1:0]             diff;
  logic signed [GAP_W-1:0]             gap;
  logic                                div_done;
  logic signed [psmw_pkg::VAL_W-1:0]   quo;

  assign wr_ok   = cmd_i.load_wr && (32'(trace_index_i) < MAX_TRACES)
                   && (32'(sample_index_i) < MAX_SAMPLES);
  assign wr_addr = AW'(32'(trace_index_i) * MAX_SAMPLES + 32'(sample_index_i));
  assign wr_tr   = TW'(trace_index_i);

  assign w_sat   = (32'(trace_count_i) > MAX_TRACES) ? LEN_W'(MAX_TRACES)
                                                     : LEN_W'(trace_count_i);
  assign cnt_sat = (32'(cfg_i.stack_count) > MAX_STACK_COUNT) ? SCW'(MAX_STACK_COUNT)
                                                              : SCW'(cfg_i.stack_count);

  assign t_s    = $signed({1'b0, t_q});
  assign top_us = psmw_pkg::TIME_SW'(top_rd_q) * $signed(psmw_pkg::TIME_SW'(psmw_pkg::US_PER_MS));
  assign bot_us = psmw_pkg::TIME_SW'(bot_rd_q) * $signed(psmw_pkg::TIME_SW'(psmw_pkg::US_PER_MS));

  assign mute_rd_en = j_q < w_q;
  assign smp_rd_en  = (p_q < len_q) && in_range_q;

  assign ps     = psmw_pkg::pct_sat(cfg_i.start_tbl, psmw_pkg::SIDX_W'(k_q));
  assign pe     = psmw_pkg::pct_sat(cfg_i.end_tbl, psmw_pkg::SIDX_W'(k_q));
  assign m_prod = PROD_W'(xm_q) * PROD_W'(psmw_pkg::RECIP_MUL);
  assign n_prod = PROD_W'(xn_q) * PROD_W'(psmw_pkg::RECIP_MUL);

  assign diff = DIV_W'(sn_q[k_q]) - DIV_W'(sm_q[k_q]);
  assign gap  = $signed({1'b0, n_q[k_q]}) - $signed({1'b0, m_q[k_q]});

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      smp_mem[wr_addr] <= sample_value_i;
      top_mem[wr_tr]   <= top_mute_ms_i;
      bot_mem[wr_tr]   <= bottom_mute_ms_i;
    end
    if (mute_rd_en) begin
      top_rd_q <= top_mem[j_q[TW-1:0]];
      bot_rd_q <= bot_mem[j_q[TW-1:0]];
    end
    if (smp_rd_en) begin
      smp_rd_q <= smp_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q         <= '0;
      k_q         <= '0;
      p_q         <= '0;
      u_run_q     <= 1'b0;
      v_run_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.req_latch) begin
        j_q     <= '0;
        u_run_q <= !cfg_i.ignore_mutes && cfg_i.use_top;
        v_run_q <= !cfg_i.ignore_mutes && cfg_i.use_bottom;
      end else if (cmd_i.scan_step) begin
        j_q <= j_q + 1'b1;
        if (!(t_s > top_us)) u_run_q <= 1'b0;
        if (!(t_s < bot_us)) v_run_q <= 1'b0;
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.acc_init) begin
        p_q <= '0;
      end else if (cmd_i.acc_step && !sts_o.acc_end) begin
        p_q <= p_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_latch) begin
      si_q       <= sample_index_i;
      w_q        <= w_sat;
      t_q        <= psmw_pkg::TIME_W'(sample_index_i * cfg_i.interval);
      in_range_q <= 32'(sample_index_i) < MAX_SAMPLES;
      cnt_q      <= cnt_sat;
      u_q        <= '0;
      v_q        <= '0;
    end else if (cmd_i.scan_step) begin
      if (u_run_q && (t_s > top_us)) u_q <= u_q + 1'b1;
      if (v_run_q && (t_s < bot_us)) v_q <= v_q + 1'b1;
    end
    if (cmd_i.win_calc) begin
      priority if (cfg_i.ignore_mutes) begin
        lo_q  <= '0;
        len_q <= w_q;
      end else if (cfg_i.use_top && !cfg_i.use_bottom) begin
        lo_q  <= '0;
        len_q <= u_q;
      end else if (cfg_i.use_bottom && !cfg_i.use_top) begin
        lo_q  <= '0;
        len_q <= v_q;
      end else if (v_q > u_q) begin
        lo_q  <= u_q;
        len_q <= v_q - u_q;
      end else begin
        lo_q  <= v_q;
        len_q <= u_q - v_q;
      end
    end
    if (cmd_i.coef_mul) begin
      xm_q <= X_W'(len_q) * X_W'(ps) + X_W'(psmw_pkg::ROUND_UP);
      xn_q <= X_W'(len_q) * X_W'(pe);
    end
    if (cmd_i.coef_div) begin
      m_q[k_q] <= LEN_W'(m_prod >> psmw_pkg::RECIP_SHIFT);
      n_q[k_q] <= LEN_W'(n_prod >> psmw_pkg::RECIP_SHIFT);
    end
    if (cmd_i.acc_init) begin
      acc_q  <= '0;
      addr_q <= AW'(32'(lo_q) * MAX_SAMPLES + 32'(si_q));
    end else if (cmd_i.acc_step) begin
      // Capture the running prefix sum at each lane's ceil and floor position.
      for (int i = 0; i < MAX_STACK_COUNT; i++) begin
        if (p_q == m_q[i]) sm_q[i] <= acc_q;
        if (p_q == n_q[i]) sn_q[i] <= acc_q;
      end
      if (!sts_o.acc_end) begin
        acc_q  <= acc_q + (in_range_q ? ACC_W'(smp_rd_q) : '0);
        addr_q <= addr_q + AW'(MAX_SAMPLES);
      end
    end
    if (cmd_i.emit) begin
      out_k_q    <= psmw_pkg::SIDX_W'(k_q);
      out_si_q   <= si_q;
      out_val_q  <= quo;
      out_last_q <= sts_o.last_k;
    end
  end

  psmw_div #(
    .DIV_W (DIV_W),
    .GAP_W (GAP_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (diff),
    .divisor_i  (gap),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  always_comb begin
    sts_o          = '0;
    sts_o.scan_end = (j_q == w_q) || (!u_run_q && !v_run_q);
    sts_o.cnt_zero = (cnt_q == '0);
    sts_o.last_k   = (SCW'(k_q) + 1'b1 == cnt_q);
    sts_o.acc_end  = (p_q == len_q);
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o        = out_valid_q;
  assign stack_index_o      = out_k_q;
  assign out_sample_index_o = out_si_q;
  assign stack_value_o      = out_val_q;
  assign last_o             = out_last_q;

endmodule

[rtl/psmw_ctrl.sv]
module psmw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           req_type_i,
  input  psmw_pkg::sts_t sts_i,
  output psmw_pkg::cmd_t cmd_o,
  output logic           in_stall_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WINDOW,
    ST_COEF_MUL,
    ST_COEF_DIV,
    ST_ACC_INIT,
    ST_ACC_RD,
    ST_ACC_ADD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   accept;

  assign accept = in_valid_i && !busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (psmw_pkg::req_e'(req_type_i) == psmw_pkg::REQ_STACK) begin
            cmd_o.req_latch = 1'b1;
            state_d         = ST_SCAN_RD;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      ST_SCAN_RD: begin
        state_d = sts_i.scan_end ? ST_WINDOW : ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd_o.scan_step = 1'b1;
        state_d         = ST_SCAN_RD;
      end
      ST_WINDOW: begin
        cmd_o.win_calc = 1'b1;
        cmd_o.k_clr    = 1'b1;
        state_d        = sts_i.cnt_zero ? ST_IDLE : ST_COEF_MUL;
      end
      ST_COEF_MUL: begin
        cmd_o.coef_mul = 1'b1;
        state_d        = ST_COEF_DIV;
      end
      ST_COEF_DIV: begin
        cmd_o.coef_div = 1'b1;
        if (sts_i.last_k) begin
          cmd_o.k_clr = 1'b1;
          state_d     = ST_ACC_INIT;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_COEF_MUL;
        end
      end
      ST_ACC_INIT: begin
        cmd_o.acc_init = 1'b1;
        state_d        = ST_ACC_RD;
      end
      ST_ACC_RD: begin
        state_d = ST_ACC_ADD;
      end
      ST_ACC_ADD: begin
        cmd_o.acc_step = 1'b1;
        state_d        = sts_i.acc_end ? ST_DIV_START : ST_ACC_RD;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_k) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = ST_DIV_START;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign in_stall_o = busy_q;

endmodule

[rtl/psmw_chk.sv]
`include "partial_stack_mute_window_macros.svh"

module psmw_chk #(
  parameter int unsigned MAX_STACK_COUNT = 8
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [psmw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input logic [psmw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               req_type_i,
  input logic [psmw_pkg::TI_W-1:0]          trace_index_i,
  input logic [psmw_pkg::SI_W-1:0]          sample_index_i,
  input logic signed [psmw_pkg::VAL_W-1:0]  sample_value_i,
  input logic signed [psmw_pkg::MUTE_W-1:0] top_mute_ms_i,
  input logic signed [psmw_pkg::MUTE_W-1:0] bottom_mute_ms_i,
  input logic [psmw_pkg::TC_W-1:0]          trace_count_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [psmw_pkg::SIDX_W-1:0]        stack_index_o,
  input logic [psmw_pkg::SI_W-1:0]          out_sample_index_o,
  input logic signed [psmw_pkg::VAL_W-1:0]  stack_value_o,
  input logic                               last_o
);

  // A stalled result holds.
  `PSMW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(stack_value_o) && $stable(stack_index_o) && $stable(last_o) && $stable(out_sample_index_o), "stalled result changed")

  // Stack numbers stay below the lane count.
  `PSMW_ASSERT(a_idx_range, out_valid_o |-> (32'(stack_index_o) < MAX_STACK_COUNT), "stack index out of range")

  // Once idle, the only pending result is the final one of its request.
  `PSMW_ASSERT(a_idle_last, (out_valid_o && !in_stall_o) |-> last_o, "idle with a non-final result pending")

  // After a non-final result is taken, the request is still in progress or
  // its next result was loaded on the same edge.
  `PSMW_ASSERT_NEXT(a_busy_mid, out_valid_o && !out_stall_i && !last_o, in_stall_o || out_valid_o, "dropped request before its final result")

endmodule

bind partial_stack_mute_window psmw_chk #(.MAX_STACK_COUNT(MAX_STACK_COUNT)) u_psmw_chk (.*);

[dv/stack_result_checker.sv]
module stack_result_checker
  import psmw_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         req_type_i,
  input  logic [TI_W-1:0]              trace_index_i,
  input  logic [SI_W-1:0]              sample_index_i,
  input  logic signed [VAL_W-1:0]      sample_value_i,
  input  logic signed [MUTE_W-1:0]     top_mute_ms_i,
  input  logic signed [MUTE_W-1:0]     bottom_mute_ms_i,
  input  logic [TC_W-1:0]              trace_count_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [SIDX_W-1:0]            stack_index_i,
  input  logic [SI_W-1:0]              out_sample_index_i,
  input  logic signed [VAL_W-1:0]      stack_value_i,
  input  logic                         last_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           results_o
);

  localparam int unsigned TRACES  = 64;
  localparam int unsigned SAMPLES = 1024;

  typedef struct {
    logic [SIDX_W-1:0]        k;
    logic [SI_W-1:0]          si;
    logic signed [VAL_W-1:0]  val;
    logic                     last;
  } stack_result_t;

  cfg_t                    cfg_q;
  logic signed [VAL_W-1:0] sample_mem [TRACES][SAMPLES];
  logic signed [MUTE_W-1:0] top_mute [TRACES];
  logic signed [MUTE_W-1:0] bot_mute [TRACES];
  stack_result_t           expected_stacks [$];

  assign pending_o = expected_stacks.size();

  function automatic int unsigned pct_of(input logic [CFG_DATA_W-1:0] tbl, input int k);
    int unsigned p;
    p = 32'((tbl >> (7 * k)) & 56'h7f);
    return (p > 100) ? 100 : p;
  endfunction

  function automatic void predict_stacks(input logic [SI_W-1:0] si, input logic [TC_W-1:0] tc);
    int unsigned w, u, v, lo, hi, len, cnt, m, n;
    longint t, q;
    longint psum [TRACES+1];
    stack_result_t r;
    w = (tc > TRACES) ? TRACES : tc;
    t = longint'(si) * longint'(cfg_q.interval);
    lo = 0;
    hi = w;
    if (!cfg_q.ignore_mutes) begin
      u = 0;
      v = 0;
      if (cfg_q.use_top)
        while (u < w && t > longint'(top_mute[u]) * 1000) u++;
      if (cfg_q.use_bottom)
        while (v < w && t < longint'(bot_mute[v]) * 1000) v++;
      if (cfg_q.use_top && !cfg_q.use_bottom) begin
        hi = u;
      end else if (cfg_q.use_bottom && !cfg_q.use_top) begin
        hi = v;
      end else begin
        lo = (u < v) ? u : v;
        hi = (u < v) ? v : u;
      end
    end
    len = hi - lo;
    psum[0] = 0;
    for (int i = 0; i < len; i++) psum[i+1] = psum[i] + longint'(sample_mem[lo+i][si]);
    cnt = (cfg_q.stack_count > 8) ? 8 : cfg_q.stack_count;
    for (int k = 0; k < cnt; k++) begin
      m = (len * pct_of(cfg_q.start_tbl, k) + 99) / 100;
      n = (len * pct_of(cfg_q.end_tbl, k)) / 100;
      q = 0;
      if (n != m) begin
        q = (psum[n] - psum[m]) / (longint'(n) - longint'(m));
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      r.k = SIDX_W'(k);
      r.si = si;
      r.val = q[31:0];
      r.last = (k + 1 == cnt);
      expected_stacks.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t e;
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
      errors_o <= 0;
      results_o <= 0;
      expected_stacks.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_IGNORE_MUTES: cfg_q.ignore_mutes = cfg_data_i[0];
          CFG_USE_TOP:      cfg_q.use_top = cfg_data_i[0];
          CFG_USE_BOTTOM:   cfg_q.use_bottom = cfg_data_i[0];
          CFG_STACK_COUNT:  cfg_q.stack_count = cfg_data_i[SC_W-1:0];
          CFG_START_TABLE:  cfg_q.start_tbl = cfg_data_i;
          CFG_END_TABLE:    cfg_q.end_tbl = cfg_data_i;
          CFG_INTERVAL:     cfg_q.interval = cfg_data_i[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (req_e'(req_type_i) == REQ_LOAD) begin
          sample_mem[trace_index_i][sample_index_i] = sample_value_i;
          top_mute[trace_index_i] = top_mute_ms_i;
          bot_mute[trace_index_i] = bottom_mute_ms_i;
        end else begin
          predict_stacks(sample_index_i, trace_count_i);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (expected_stacks.size() == 0) begin
          $error("unexpected result: stack_index %0d value %0d", stack_index_i, stack_value_i);
          errors_o <= errors_o + 1;
        end else begin
          e = expected_stacks.pop_front();
          if (e.k !== stack_index_i || e.si !== out_sample_index_i ||
              e.val !== stack_value_i || e.last !== last_i) begin
            errors_o <= errors_o + 1;
            if (e.k !== stack_index_i)
              $error("stack_index expected %0d got %0d", e.k, stack_index_i);
            if (e.si !== out_sample_index_i)
              $error("out_sample_index expected %0d got %0d", e.si, out_sample_index_i);
            if (e.val !== stack_value_i)
              $error("stack_value expected %0d got %0d", e.val, stack_value_i);
            if (e.last !== last_i)
              $error("last expected %0d got %0d", e.last, last_i);
          end
        end
      end
    end
  end

endmodule

[dv/partial_stack_mute_window_tb.sv]
module partial_stack_mute_window_tb;
  import psmw_pkg::*;

  localparam int LIMIT = 3000000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      req_type_i = 1'b0;
  logic [TI_W-1:0]           trace_index_i = '0;
  logic [SI_W-1:0]           sample_index_i = '0;
  logic signed [VAL_W-1:0]   sample_value_i = '0;
  logic signed [MUTE_W-1:0]  top_mute_ms_i = '0;
  logic signed [MUTE_W-1:0]  bottom_mute_ms_i = '0;
  logic [TC_W-1:0]           trace_count_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [SIDX_W-1:0]         stack_index_o;
  logic [SI_W-1:0]           out_sample_index_o;
  logic signed [VAL_W-1:0]   stack_value_o;
  logic                      last_o;

  int errors, pending, results;
  int cycles = 0;
  int stacks_sent = 0;
  int loads_sent = 0;
  bit hold_off = 1'b0;

  // Sample indexes at which every trace has been loaded; stacks only read these.
  int ready_si [$] = '{0, 2, 511, 1023};

  always #6 clk_i = ~clk_i;

  partial_stack_mute_window DUT (.*);

  stack_result_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .trace_index_i,
    .sample_index_i, .sample_value_i, .top_mute_ms_i, .bottom_mute_ms_i,
    .trace_count_i, .out_valid_i(out_valid_o), .out_stall_i, .stack_index_i(stack_index_o),
    .out_sample_index_i(out_sample_index_o), .stack_value_i(stack_value_o),
    .last_i(last_o), .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, mostly short, a few long; a hold-off request
  // blocks the result channel so the block backs up.
  initial begin
    int n;
    int r;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
        continue;
      end
      r = $urandom_range(0, 99);
      n = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(15, 60);
      if (n == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mix full-range mutes with mutes near sample times so windows open and close.
  function automatic logic [MUTE_W-1:0] pick_mute();
    return ($urandom_range(0, 1) != 0) ? MUTE_W'($urandom) : MUTE_W'($urandom_range(0, 4200));
  endfunction

  // Offer one request; hold it until accepted, then idle for the given gap.
  task automatic send_request(input req_e kind, input logic [TI_W-1:0] ti,
                              input logic [SI_W-1:0] si, input logic [VAL_W-1:0] val,
                              input logic [MUTE_W-1:0] top, input logic [MUTE_W-1:0] bot,
                              input logic [TC_W-1:0] tc, input int gap);
    bit stalled;
    req_type_i <= kind;
    trace_index_i <= ti;
    sample_index_i <= si;
    sample_value_i <= val;
    top_mute_ms_i <= top;
    bottom_mute_ms_i <= bot;
    trace_count_i <= tc;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    if (kind == REQ_STACK) stacks_sent++;
    else loads_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load(input logic [TI_W-1:0] ti, input logic [SI_W-1:0] si,
                      input logic [VAL_W-1:0] val, input logic [MUTE_W-1:0] top,
                      input logic [MUTE_W-1:0] bot);
    send_request(REQ_LOAD, ti, si, val, top, bot, '0, pick_gap());
  endtask

  task automatic stack(input logic [SI_W-1:0] si, input logic [TC_W-1:0] tc);
    send_request(REQ_STACK, TI_W'($urandom), si, $urandom, MUTE_W'($urandom),
                 MUTE_W'($urandom), tc, pick_gap());
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, drain expected results, then let a stack with no results finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_table();
    return {$urandom, $urandom} & {CFG_DATA_W{1'b1}};
  endfunction

  task automatic random_items(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        stack(SI_W'(ready_si[$urandom_range(0, ready_si.size() - 1)]),
              ($urandom_range(0, 9) < 7) ? TC_W'($urandom_range(1, 64)) : TC_W'($urandom));
      end else if (r < 90) begin
        load(TI_W'($urandom), SI_W'(ready_si[$urandom_range(0, ready_si.size() - 1)]),
             $urandom, pick_mute(), pick_mute());
      end else begin
        // write at an arbitrary address that stacks never read
        load(TI_W'($urandom), SI_W'($urandom), $urandom, pick_mute(), pick_mute());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every trace at every readable sample index.
    foreach (ready_si[j])
      for (int tr = 0; tr < 64; tr++)
        send_request(REQ_LOAD, TI_W'(tr), SI_W'(ready_si[j]), $urandom, pick_mute(),
                     pick_mute(), '0, 0);

    // Directed part under reset settings: field extremes and window corners.
    load(6'd0, 10'd1023, 32'h7fffffff, 16'sh7fff, 16'sh8000);
    load(6'd63, 10'd1023, 32'h80000000, 16'sh8000, 16'sh7fff);
    load(6'd1, 10'd0, 32'h80000000, 16'sh0000, 16'sh0000);
    stack(10'd0, 7'd0);
    stack(10'd1023, 7'd64);
    stack(10'd0, 7'd127);
    stack(10'd511, 7'd1);
    stack(10'd1023, 7'd65);
    random_items(30);
    drain();

    // Top only, all eight stacks, random ranges incl. percents above 100.
    write_reg(CFG_IGNORE_MUTES, 0);
    write_reg(CFG_USE_TOP, 1);
    write_reg(CFG_USE_BOTTOM, 0);
    write_reg(CFG_STACK_COUNT, 8);
    write_reg(CFG_START_TABLE, rand_table());
    write_reg(CFG_END_TABLE, rand_table());
    write_reg(CFG_INTERVAL, 4000);
    stack(10'd2, 7'd64);
    stack(10'd1023, 7'd64);
    random_items(30);
    drain();

    // Bottom only, single stack, shortest interval.
    write_reg(CFG_USE_TOP, 0);
    write_reg(CFG_USE_BOTTOM, 1);
    write_reg(CFG_STACK_COUNT, 1);
    write_reg(CFG_START_TABLE, '0);
    write_reg(CFG_END_TABLE, {8{7'd100}});
    write_reg(CFG_INTERVAL, 1);
    random_items(25);
    drain();

    // Both mutes, stack count above the maximum, longest interval; then
    // hold the result channel so the block fills and stalls requests.
    write_reg(CFG_USE_TOP, 1);
    write_reg(CFG_STACK_COUNT, 15);
    write_reg(CFG_START_TABLE, {8{7'd127}});
    write_reg(CFG_END_TABLE, rand_table());
    write_reg(CFG_INTERVAL, 16'hffff);
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++)
      send_request(REQ_STACK, '0, SI_W'(ready_si[i % ready_si.size()]), '0, '0, '0,
                   7'd64, 0);
    random_items(20);
    drain();

    // Stack count zero yields nothing; reversed ranges with all traces.
    write_reg(CFG_IGNORE_MUTES, 1);
    write_reg(CFG_STACK_COUNT, 0);
    stack(10'd100, 7'd64);
    stack(10'd3, 7'd10);
    drain();
    write_reg(CFG_STACK_COUNT, 8);
    write_reg(CFG_START_TABLE, {8{7'd90}});
    write_reg(CFG_END_TABLE, {7'd0, 7'd10, 7'd25, 7'd50, 7'd75, 7'd89, 7'd90, 7'd95});
    random_items(25);
    drain();

    // No mute enabled: empty windows.
    write_reg(CFG_IGNORE_MUTES, 0);
    write_reg(CFG_USE_TOP, 0);
    write_reg(CFG_USE_BOTTOM, 0);
    random_items(15);
    drain();

    // Random settings, with the bottom mute always on.
    write_reg(CFG_USE_TOP, $urandom);
    write_reg(CFG_USE_BOTTOM, 1);
    write_reg(CFG_STACK_COUNT, $urandom_range(1, 8));
    write_reg(CFG_START_TABLE, rand_table());
    write_reg(CFG_END_TABLE, rand_table());
    write_reg(CFG_INTERVAL, $urandom_range(1, 65535));
    random_items(25);
    drain();

    $display("Covered %0d loads and %0d stack requests, %0d results checked,",
             loads_sent, stacks_sent, results);
    $display("across top, bottom, both, no-mute and ignore-mute windows.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
